// ----- rtl/core/sparse_conv3d_rulebook_gen_macros.svh -----
// Assertion macros shared by the rulebook generator RTL.
`ifndef SPARSE_CONV3D_RULEBOOK_GEN_MACROS_SVH
`define SPARSE_CONV3D_RULEBOOK_GEN_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SC3RB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SC3RB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sc3rb_pkg.sv -----
// Types and constants for the sparse 3-D convolution rulebook generator.
`default_nettype none

package sc3rb_pkg;

    // Field widths
    localparam int BATCH_W   = 8;
    localparam int COORD_W   = 12;
    localparam int FEAT_W    = 13;   // coordinate plus padding
    localparam int SIZE_W    = 13;
    localparam int DIMS_W    = 12;   // three packed nibbles
    localparam int STRIDE_W  = 4;
    localparam int KSZ_W     = 3;    // kernel size 1..4
    localparam int KOFF_W    = 2;    // kernel offset 0..3
    localparam int TAP_W     = 6;
    localparam int OFF_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Divider step count
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(FEAT_W);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIMS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_DIMS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DEPTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 3'd5;

    // Register reset values
    localparam logic [DIMS_W-1:0] KERNEL_DIMS_RST = 12'h333;
    localparam logic [DIMS_W-1:0] STRIDE_DIMS_RST = 12'h111;
    localparam logic [DIMS_W-1:0] PAD_DIMS_RST    = 12'h000;
    localparam logic [SIZE_W-1:0] OUT_SIZE_RST    = 13'd1;

    // Axis codes
    localparam logic [1:0] AX_D = 2'd0;
    localparam logic [1:0] AX_H = 2'd1;
    localparam logic [1:0] AX_W = 2'd2;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sparse_conv3d_rulebook_gen.sv -----
// Top level of the sparse 3-D convolution rulebook generator.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the kernel,
//   stride and padding nibbles and the output grid sizes; cfg_ready is always
//   high. Write only while no voxel is in flight.
//   voxel channel (voxel_valid/voxel_ready) takes one active input voxel.
//   hit channel (hit_valid/hit_ready) returns one transaction per output
//   position the voxel touches, depth-major, last_hit on the final one.
// Timing:
//   Each axis needs one 13-step stride division on the shared serial divider,
//   the three axes in turn. A voxel with no hit is done after the third
//   division. Otherwise the shared 32x13 multiplier builds the start offset in
//   steps (H*W, D*H*W, batch, depth, height, sum), and hits follow at one per
//   cycle while hit_ready is high. voxel_ready is high only in the idle state.
// Stalls: the hit output register holds until taken; the walk pauses.
// Reset: registers return to their reset values and the block idles.
`default_nettype none
`include "sparse_conv3d_rulebook_gen_macros.svh"

module sparse_conv3d_rulebook_gen #(
    parameter int MAX_KERNEL_DIM = 4,
    parameter int MAX_GRID_DIM   = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sc3rb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sc3rb_pkg::SIZE_W-1:0]       cfg_data,
    // input voxels
    input  logic                               voxel_valid,
    output logic                               voxel_ready,
    input  logic [sc3rb_pkg::BATCH_W-1:0]      batch_id,
    input  logic [sc3rb_pkg::COORD_W-1:0]      coord_d,
    input  logic [sc3rb_pkg::COORD_W-1:0]      coord_h,
    input  logic [sc3rb_pkg::COORD_W-1:0]      coord_w,
    // output hits
    output logic                               hit_valid,
    input  logic                               hit_ready,
    output logic [sc3rb_pkg::OFF_W-1:0]        out_offset,
    output logic [sc3rb_pkg::TAP_W-1:0]        tap_index,
    output logic [sc3rb_pkg::BATCH_W-1:0]      out_batch,
    output logic [sc3rb_pkg::COORD_W-1:0]      out_d,
    output logic [sc3rb_pkg::COORD_W-1:0]      out_h,
    output logic [sc3rb_pkg::COORD_W-1:0]      out_w,
    output logic                               last_hit
);
    import sc3rb_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Multiplier steps
    localparam logic [2:0] MS_HW   = 3'd0;  // H*W
    localparam logic [2:0] MS_DHW  = 3'd1;  // D*H*W
    localparam logic [2:0] MS_BOFF = 3'd2;  // batch*D*H*W
    localparam logic [2:0] MS_DOFF = 3'd3;  // d0*H*W
    localparam logic [2:0] MS_HOFF = 3'd4;  // h0*W
    localparam logic [2:0] MS_SUM  = 3'd5;  // final sum

    // Configuration registers
    logic [DIMS_W-1:0] kernel_dims_reg;
    logic [DIMS_W-1:0] stride_dims_reg;
    logic [DIMS_W-1:0] pad_dims_reg;
    logic [SIZE_W-1:0] out_depth_reg;
    logic [SIZE_W-1:0] out_height_reg;
    logic [SIZE_W-1:0] out_width_reg;

    // Per-axis settings
    logic [KSZ_W-1:0]    k_ax   [3];
    logic [STRIDE_W-1:0] s_ax   [3];
    logic [SIZE_W-1:0]   sz_ax  [3];
    logic [SIZE_W-1:0]   sz_cfg [3];
    logic [3:0]          p_ax   [3];
    logic [COORD_W-1:0]  c_in   [3];
    logic [FEAT_W-1:0]   feat_in[3];

    // Sequencer
    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_nx;
    logic [2:0] mstep_reg;
    logic       empty_reg;
    logic       voxel_acc;

    // Divider
    logic                  div_start;
    logic [FEAT_W-1:0]     div_dividend;
    logic [STRIDE_W-1:0]   div_divisor;
    logic [FEAT_W-1:0]     div_q;
    logic [STRIDE_W-1:0]   div_r;
    div_stat_t             div_stat;

    // Axis range
    logic                c_pos;
    logic                r_lt;
    logic [3:0]          n_full;
    logic [1:0]          nc;
    logic [1:0]          qm;
    logic [5:0]          kd_full;
    logic [FEAT_W-1:0]   q_inc;
    logic [FEAT_W-1:0]   ax_beg;
    logic [FEAT_W-1:0]   ax_end;
    logic [KOFF_W-1:0]   ax_kd;
    logic                ax_empty;

    // Per-voxel data
    logic [BATCH_W-1:0]  batch_reg;
    logic [FEAT_W-1:0]   feat_reg[3];
    logic [FEAT_W-1:0]   beg_reg [3];
    logic [FEAT_W-1:0]   end_reg [3];
    logic [KOFF_W-1:0]   kd0_reg [3];

    // Shared multiplier
    logic [OFF_W-1:0]    mul_a;
    logic [SIZE_W-1:0]   mul_b;
    logic [OFF_W-1:0]    mul_lo;
    logic [OFF_W-1:0]    prod_reg;
    logic [OFF_W-1:0]    hw_reg;
    logic [OFF_W-1:0]    acc_reg;
    logic [OFF_W-1:0]    start_off;

    // Walk
    logic [FEAT_W-1:0]   d_reg, h_reg, w_reg;
    logic [KOFF_W-1:0]   kd_reg, kh_reg, kw_reg;
    logic [OFF_W-1:0]    cur_reg, base_h_reg, base_d_reg;
    logic [OFF_W-1:0]    sz_w32;
    logic                w_end, h_end, d_end, is_last;
    logic [4:0]          khw;
    logic [6:0]          ktot;
    logic [TAP_W-1:0]    tap_cur;
    logic                hit_load;

    // Output register
    logic                hit_valid_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [TAP_W-1:0]    tap_reg;
    logic [BATCH_W-1:0]  obatch_reg;
    logic [COORD_W-1:0]  od_reg, oh_reg, ow_reg;
    logic                olast_reg;

    // Register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_dims_reg <= KERNEL_DIMS_RST;
            stride_dims_reg <= STRIDE_DIMS_RST;
            pad_dims_reg    <= PAD_DIMS_RST;
            out_depth_reg   <= OUT_SIZE_RST;
            out_height_reg  <= OUT_SIZE_RST;
            out_width_reg   <= OUT_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KERNEL_DIMS: kernel_dims_reg <= cfg_data[DIMS_W-1:0];
                REG_STRIDE_DIMS: stride_dims_reg <= cfg_data[DIMS_W-1:0];
                REG_PAD_DIMS:    pad_dims_reg    <= cfg_data[DIMS_W-1:0];
                REG_OUT_DEPTH:   out_depth_reg   <= cfg_data;
                REG_OUT_HEIGHT:  out_height_reg  <= cfg_data;
                REG_OUT_WIDTH:   out_width_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Unpack and clamp the per-axis settings
    always_comb
    begin
        logic [3:0] k_nib;
        logic [3:0] s_nib;
        sz_cfg[0] = out_depth_reg;
        sz_cfg[1] = out_height_reg;
        sz_cfg[2] = out_width_reg;
        c_in[0]   = coord_d;
        c_in[1]   = coord_h;
        c_in[2]   = coord_w;
        for (int a = 0; a < 3; a++)
        begin
            k_nib = kernel_dims_reg[4*(2-a) +: 4];
            s_nib = stride_dims_reg[4*(2-a) +: 4];
            p_ax[a] = pad_dims_reg[4*(2-a) +: 4];
            if (k_nib == 4'd0)
            begin
                k_ax[a] = KSZ_W'(1);
            end
            else if (32'(k_nib) > 32'(MAX_KERNEL_DIM))
            begin
                k_ax[a] = KSZ_W'(MAX_KERNEL_DIM);
            end
            else
            begin
                k_ax[a] = KSZ_W'(k_nib);
            end
            s_ax[a] = (s_nib == 4'd0) ? STRIDE_W'(1) : s_nib;
            if (32'(sz_cfg[a]) > 32'(MAX_GRID_DIM))
            begin
                sz_ax[a] = SIZE_W'(MAX_GRID_DIM);
            end
            else
            begin
                sz_ax[a] = sz_cfg[a];
            end
            feat_in[a] = FEAT_W'(c_in[a]) + FEAT_W'(p_ax[a]);
        end
    end

    // Divider feed
    assign voxel_acc    = voxel_valid && voxel_ready;
    assign axis_nx      = (axis_reg == AX_W) ? AX_W : 2'(axis_reg + 2'd1);
    assign div_start    = voxel_acc ||
                          ((state_reg == ST_DIV) && div_stat.done && (axis_reg != AX_W));
    assign div_dividend = (state_reg == ST_IDLE) ? feat_in[AX_D] : feat_reg[axis_nx];
    assign div_divisor  = (state_reg == ST_IDLE) ? s_ax[AX_D] : s_ax[axis_nx];

    sc3rb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    // Range on the current axis from q = f / s, r = f % s.
    // beg = ceil((f+1-k)/s) clamped at 0 = q + ceil((r+1-k)/s); kd = f - beg*s.
    always_comb
    begin
        c_pos  = div_r >= {1'b0, k_ax[axis_reg]};
        r_lt   = ({1'b0, div_r} + 5'd1) < {2'b0, k_ax[axis_reg]};
        n_full = {1'b0, k_ax[axis_reg]} - 4'd1 - div_r;
        nc     = 2'd0;
        if (r_lt)
        begin
            case (s_ax[axis_reg])
                4'd1:    nc = n_full[1:0];
                4'd2:    nc = {1'b0, n_full[1]};
                4'd3:    nc = {1'b0, (n_full[1:0] == 2'd3)};
                default: nc = 2'd0;
            endcase
        end
        qm       = (div_q >= FEAT_W'(nc)) ? nc : div_q[1:0];
        q_inc    = div_q + FEAT_W'(1);
        ax_beg   = c_pos ? q_inc : (div_q - FEAT_W'(qm));
        kd_full  = {2'b0, div_r} + ({4'b0, qm} * {2'b0, s_ax[axis_reg]});
        ax_kd    = kd_full[KOFF_W-1:0];
        ax_end   = (q_inc < sz_ax[axis_reg]) ? q_inc : sz_ax[axis_reg];
        ax_empty = ax_beg >= ax_end;
    end

    // Shared multiplier operands
    always_comb
    begin
        case (mstep_reg)
            MS_HW:
            begin
                mul_a = OFF_W'(sz_ax[AX_H]);
                mul_b = sz_ax[AX_W];
            end
            MS_DHW:
            begin
                mul_a = prod_reg;
                mul_b = sz_ax[AX_D];
            end
            MS_BOFF:
            begin
                mul_a = prod_reg;
                mul_b = SIZE_W'(batch_reg);
            end
            MS_DOFF:
            begin
                mul_a = hw_reg;
                mul_b = beg_reg[AX_D];
            end
            MS_HOFF:
            begin
                mul_a = OFF_W'(sz_ax[AX_W]);
                mul_b = beg_reg[AX_H];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_lo    = OFF_W'(mul_a * mul_b);
    assign start_off = acc_reg + prod_reg + OFF_W'(beg_reg[AX_W]);

    // Walk position
    assign sz_w32   = OFF_W'(sz_ax[AX_W]);
    assign w_end    = (w_reg + FEAT_W'(1)) == end_reg[AX_W];
    assign h_end    = (h_reg + FEAT_W'(1)) == end_reg[AX_H];
    assign d_end    = (d_reg + FEAT_W'(1)) == end_reg[AX_D];
    assign is_last  = w_end && h_end && d_end;
    assign khw      = {2'b0, k_ax[AX_H]} * {2'b0, k_ax[AX_W]};
    assign ktot     = {2'b0, khw} * {4'b0, k_ax[AX_D]};
    assign tap_cur  = ({4'b0, kd_reg} * {1'b0, khw})
                    + ({4'b0, kh_reg} * {3'b0, k_ax[AX_W]})
                    + {4'b0, kw_reg};
    assign hit_load = (state_reg == ST_EMIT) && (!hit_valid_reg || hit_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (voxel_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done && (axis_reg == AX_W))
                begin
                    state_next = (empty_reg || ax_empty) ? ST_IDLE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mstep_reg == MS_SUM)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (hit_load && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AX_D;
            mstep_reg     <= MS_HW;
            empty_reg     <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (voxel_acc)
            begin
                axis_reg  <= AX_D;
                empty_reg <= 1'b0;
            end
            else if ((state_reg == ST_DIV) && div_stat.done)
            begin
                axis_reg  <= axis_nx;
                empty_reg <= empty_reg || ax_empty;
                mstep_reg <= MS_HW;
            end
            else if (state_reg == ST_MUL)
            begin
                mstep_reg <= 3'(mstep_reg + 3'd1);
            end
            if (hit_load)
            begin
                hit_valid_reg <= 1'b1;
            end
            else if (hit_ready)
            begin
                hit_valid_reg <= 1'b0;
            end
        end
    end

    // Voxel capture and per-axis ranges
    always_ff @(posedge clk)
    begin
        if (voxel_acc)
        begin
            batch_reg <= batch_id;
            for (int a = 0; a < 3; a++)
            begin
                feat_reg[a] <= feat_in[a];
            end
        end
        if ((state_reg == ST_DIV) && div_stat.done)
        begin
            beg_reg[axis_reg] <= ax_beg;
            end_reg[axis_reg] <= ax_end;
            kd0_reg[axis_reg] <= ax_kd;
        end
    end

    // Offset build and the depth-major walk
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_lo;
            case (mstep_reg)
                MS_DHW:  hw_reg  <= prod_reg;
                MS_DOFF: acc_reg <= prod_reg;
                MS_HOFF: acc_reg <= acc_reg + prod_reg;
                MS_SUM:
                begin
                    d_reg      <= beg_reg[AX_D];
                    h_reg      <= beg_reg[AX_H];
                    w_reg      <= beg_reg[AX_W];
                    kd_reg     <= kd0_reg[AX_D];
                    kh_reg     <= kd0_reg[AX_H];
                    kw_reg     <= kd0_reg[AX_W];
                    cur_reg    <= start_off;
                    base_h_reg <= start_off;
                    base_d_reg <= start_off;
                end
                default: ;
            endcase
        end
        if (hit_load)
        begin
            off_reg    <= cur_reg;
            tap_reg    <= tap_cur;
            obatch_reg <= batch_reg;
            od_reg     <= d_reg[COORD_W-1:0];
            oh_reg     <= h_reg[COORD_W-1:0];
            ow_reg     <= w_reg[COORD_W-1:0];
            olast_reg  <= is_last;
            if (!w_end)
            begin
                w_reg   <= w_reg + FEAT_W'(1);
                kw_reg  <= kw_reg - s_ax[AX_W][KOFF_W-1:0];
                cur_reg <= cur_reg + OFF_W'(1);
            end
            else if (!h_end)
            begin
                h_reg      <= h_reg + FEAT_W'(1);
                w_reg      <= beg_reg[AX_W];
                kh_reg     <= kh_reg - s_ax[AX_H][KOFF_W-1:0];
                kw_reg     <= kd0_reg[AX_W];
                base_h_reg <= base_h_reg + sz_w32;
                cur_reg    <= base_h_reg + sz_w32;
            end
            else
            begin
                d_reg      <= d_reg + FEAT_W'(1);
                h_reg      <= beg_reg[AX_H];
                w_reg      <= beg_reg[AX_W];
                kd_reg     <= kd_reg - s_ax[AX_D][KOFF_W-1:0];
                kh_reg     <= kd0_reg[AX_H];
                kw_reg     <= kd0_reg[AX_W];
                base_d_reg <= base_d_reg + hw_reg;
                base_h_reg <= base_d_reg + hw_reg;
                cur_reg    <= base_d_reg + hw_reg;
            end
        end
    end

    // Ports
    assign voxel_ready = (state_reg == ST_IDLE);
    assign hit_valid   = hit_valid_reg;
    assign out_offset  = off_reg;
    assign tap_index   = tap_reg;
    assign out_batch   = obatch_reg;
    assign out_d       = od_reg;
    assign out_h       = oh_reg;
    assign out_w       = ow_reg;
    assign last_hit    = olast_reg;

    // Checks
    `SC3RB_ASSERT_NEXT(a_voxel_starts_div, voxel_valid && voxel_ready, div_stat.busy, "divider not started on voxel")
    `SC3RB_ASSERT_IMPL(a_walk_in_range, state_reg == ST_EMIT, (d_reg < end_reg[AX_D]) && (h_reg < end_reg[AX_H]) && (w_reg < end_reg[AX_W]), "walk outside output range")
    `SC3RB_ASSERT_IMPL(a_tap_in_kernel, hit_valid_reg, {1'b0, tap_reg} < ktot, "tap index beyond kernel volume")

endmodule

`default_nettype wire

// ----- rtl/core/sc3rb_div.sv -----
// Bit-serial restoring divider: padded coordinate by stride, one quotient bit a cycle.
`default_nettype none

module sc3rb_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sc3rb_pkg::FEAT_W-1:0]      dividend,
    input  logic [sc3rb_pkg::STRIDE_W-1:0]    divisor,
    output logic [sc3rb_pkg::FEAT_W-1:0]      quotient,
    output logic [sc3rb_pkg::STRIDE_W-1:0]    remainder,
    output sc3rb_pkg::div_stat_t              stat
);
    import sc3rb_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [FEAT_W-1:0]    shift_reg;
    logic [FEAT_W-1:0]    shift_next;
    logic [STRIDE_W-1:0]  rem_reg;
    logic [STRIDE_W-1:0]  rem_next;
    logic [STRIDE_W-1:0]  div_reg;
    logic [STRIDE_W:0]    rem_sh;
    logic                 q_bit;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh = {rem_reg, shift_reg[FEAT_W-1]};
        q_bit  = rem_sh >= {1'b0, div_reg};
        if (q_bit)
        begin
            rem_next = STRIDE_W'(rem_sh - {1'b0, div_reg});
        end
        else
        begin
            rem_next = rem_sh[STRIDE_W-1:0];
        end
        shift_next = {shift_reg[FEAT_W-2:0], q_bit};
    end

    // Step counter and completion flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DIV_STEPS;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DIV_CNT_W'(1));
            end
        end
    end

    // Operand and partial-result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign quotient  = shift_reg;
    assign remainder = rem_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

`default_nettype wire
